// ----- hdl/lapf_pkg.sv -----
`timescale 1ns / 1ps

package lapf_pkg;

	localparam int PIX_W   = 8;
	localparam int CFG_W   = 11;
	localparam int ROW_W   = 10;
	localparam int COORD_W = 10;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam int MIN_SIZE   = 3;
	localparam int MAX_HEIGHT = 1024;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} pix_col_t;

endpackage

// ----- hdl/lapf_col_cell.sv -----
`timescale 1ns / 1ps

module lapf_col_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  lapf_pkg::pix_col_t col_in,
	output lapf_pkg::pix_col_t col_out
);
	import lapf_pkg::*;

	pix_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

// ----- hdl/lapf_line_store.sv -----
`timescale 1ns / 1ps

module lapf_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/laplacian_3x3_edge_filter_top.sv -----
`timescale 1ns / 1ps

// 3x3 four-neighbour Laplacian over a raster-order 8-bit grayscale stream.
// Input channel: pixel with in_valid / in_stall; one pixel is taken per beat.
// Output channel: edge_value, center_column, center_row, frame_last with
// out_valid / out_stall; one beat per interior pixel, none for border pixels.
// Frame size comes from two APB registers: frame_width at 0x0, frame_height
// at 0x4; write them only while the stream is quiet.
// Each taken pixel passes the line store read stage and then the output
// register, which yields the result for the centre one column left and one
// row up.
// Throughput: one pixel per clock while the output is not stalled, set by
// the single-port-per-side line store (one read and one write a cycle) and
// the two-cell window chain. A stalled result holds in the output register;
// one more pixel may enter and wait in the read stage, after which in_stall
// rises until the receiver takes the result.
// Reset clears the counters, the window cells and all valid flags and loads
// 640 x 480; line store contents are unknown until the first line is seen.
module laplacian_3x3_edge_filter_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lapf_pkg::PIX_W-1:0]        pixel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lapf_pkg::PIX_W-1:0]        edge_value,
	output logic [lapf_pkg::COORD_W-1:0]      center_column,
	output logic [lapf_pkg::COORD_W-1:0]      center_row,
	output logic                              frame_last,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lapf_pkg::APB_AW-1:0]       paddr,
	input  logic [lapf_pkg::APB_DW-1:0]       pwdata,
	output logic [lapf_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);
	import lapf_pkg::*;

	localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int SZ_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam int XW    = (CNT_W > COORD_W) ? CNT_W : COORD_W;
	localparam int RST_LAST_COL = ((640 > MAX_WIDTH) ? MAX_WIDTH : 640) - 1;
	localparam int RST_LAST_ROW = 480 - 1;

	// ---------------- configuration ----------------
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [CNT_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;
	logic             cfg_wr;
	logic [SZ_W-1:0]  fw_x, fh_x, w_clamp, h_clamp, w_last, h_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, frame_width_q};
			REG_FRAME_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, frame_height_q};
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		fw_x = SZ_W'(frame_width_q);
		fh_x = SZ_W'(frame_height_q);
		if (fw_x < SZ_W'(MIN_SIZE))       w_clamp = SZ_W'(MIN_SIZE);
		else if (fw_x > SZ_W'(MAX_WIDTH)) w_clamp = SZ_W'(MAX_WIDTH);
		else                              w_clamp = fw_x;
		if (fh_x < SZ_W'(MIN_SIZE))        h_clamp = SZ_W'(MIN_SIZE);
		else if (fh_x > SZ_W'(MAX_HEIGHT)) h_clamp = SZ_W'(MAX_HEIGHT);
		else                               h_clamp = fh_x;
		w_last = w_clamp - SZ_W'(1);
		h_last = h_clamp - SZ_W'(1);
	end

	// last indices registered from the sizes; user keeps writes idle-only, unenforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CNT_W'(RST_LAST_COL);
			last_row_q <= ROW_W'(RST_LAST_ROW);
		end else begin
			last_col_q <= w_last[CNT_W-1:0];
			last_row_q <= h_last[ROW_W-1:0];
		end
	end

	// ---------------- handshake and counters ----------------
	logic             in_acc, advance;
	logic             s1_valid_q, out_valid_q;
	logic [CNT_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             line_end, frame_end, produce;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !advance;
	assign in_acc   = in_valid && !in_stall;

	assign line_end  = col_q >= last_col_q;
	assign frame_end = line_end && (row_q >= last_row_q);
	assign produce   = (col_q >= CNT_W'(2)) && (row_q >= ROW_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// ---------------- read stage ----------------
	logic [CNT_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             prod_s1, last_s1;
	logic [2*PIX_W-1:0] ls_rd, ls_wr;
	logic             step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1  <= col_q;
			row_s1  <= row_q;
			pix_s1  <= pixel;
			prod_s1 <= produce;
			last_s1 <= frame_end;
		end
	end

	assign step = s1_valid_q && advance;

	// packed as {upper line, middle line}
	assign ls_wr = {ls_rd[PIX_W-1:0], pix_s1};

	lapf_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CNT_W),
		.DW    (2*PIX_W)
	) u_line_store (
		.clk     (clk),
		.wr_en   (step),
		.wr_addr (col_s1),
		.wr_data (ls_wr),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (ls_rd)
	);

	// ---------------- window chain ----------------
	pix_col_t cur_col, col_x1, col_x2;

	assign cur_col.top = ls_rd[2*PIX_W-1:PIX_W];
	assign cur_col.mid = ls_rd[PIX_W-1:0];
	assign cur_col.bot = pix_s1;

	lapf_col_cell u_cell_x1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (step),
		.col_in  (cur_col),
		.col_out (col_x1)
	);

	lapf_col_cell u_cell_x2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (step),
		.col_in  (col_x1),
		.col_out (col_x2)
	);

	// ---------------- Laplacian and output register ----------------
	logic signed [PIX_W+3:0] lap;
	logic [PIX_W-1:0]        lap_sat;
	logic [XW-1:0]           col_m1;
	logic [ROW_W-1:0]        row_m1;

	always_comb begin
		lap = $signed({4'b0, col_x1.top}) + $signed({4'b0, col_x2.mid})
		    + $signed({4'b0, cur_col.mid}) + $signed({4'b0, col_x1.bot})
		    - $signed({2'b0, col_x1.mid, 2'b0});
		if (lap < 0)
			lap_sat = '0;
		else if (lap > $signed({4'b0, EDGE_MAX}))
			lap_sat = EDGE_MAX;
		else
			lap_sat = lap[PIX_W-1:0];
		col_m1 = XW'(col_s1) - XW'(1);
		row_m1 = row_s1 - ROW_W'(1);
	end

	logic [PIX_W-1:0]   edge_value_q;
	logic [COORD_W-1:0] center_column_q, center_row_q;
	logic               frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			edge_value_q    <= lap_sat;
			center_column_q <= col_m1[COORD_W-1:0];
			center_row_q    <= COORD_W'(row_m1);
			frame_last_q    <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign edge_value    = edge_value_q;
	assign center_column = center_column_q;
	assign center_row    = center_row_q;
	assign frame_last    = frame_last_q;

endmodule
